// File: rtl/core/fapat_pkg.sv
// fapat_pkg: widths, gains, register indexes and the saturating helpers
// shared by the four-axis pid controller, datapath and top level
// no dependencies

package fapat_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int NUM_AXES   = 4;
    localparam int AXIS_W     = $clog2(NUM_AXES);
    localparam int OUT_W      = 18;
    localparam int TS_W       = 17;
    localparam int RATE_W     = 31;
    localparam int THR_W      = 31;
    localparam int LIM_W      = 18;
    localparam int TILT_W     = 17;
    localparam int CFG_DATA_W = 31;
    localparam int CFG_IDX_W  = 4;

    typedef logic signed [DATA_WIDTH-1:0] word_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic [AXIS_W-1:0]            axis_t;

    localparam word_t WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // axis order: x drives roll, y pitch, heading yaw, z throttle
    localparam axis_t AXIS_X   = 2'd0;
    localparam axis_t AXIS_Y   = 2'd1;
    localparam axis_t AXIS_YAW = 2'd2;
    localparam axis_t AXIS_Z   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_RATE  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INT_THR    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_GATE   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THR_BIAS   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_LIMIT = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_THR_MIN    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_THR_MAX    = 4'd7;

    // gains in q16.16, rounded to nearest
    localparam word_t KP_XY  = 32'sd19661;
    localparam word_t KI_XY  = 32'sd6554;
    localparam word_t KD_XY  = 32'sd39322;
    localparam word_t KP_YAW = 32'sd328;
    localparam word_t KI_YAW = 32'sd66;
    localparam word_t KD_YAW = 32'sd328;
    localparam word_t KP_Z   = 32'sd22938;
    localparam word_t KI_Z   = 32'sd6554;
    localparam word_t KD_Z   = 32'sd13107;

    // one multiply per op, issued in this order for each axis
    typedef enum logic [2:0] {
        OP_DIFF,
        OP_TS,
        OP_KP,
        OP_KI,
        OP_KD
    } op_t;

    typedef struct packed {
        logic  load_err;
        logic  mul_en;
        op_t   mul_op;
        axis_t mul_axis;
        logic  load_out;
    } cmd_t;

    function automatic word_t kp_gain(input axis_t ax);
        case (ax)
            AXIS_YAW: return KP_YAW;
            AXIS_Z:   return KP_Z;
            default:  return KP_XY;
        endcase
    endfunction

    function automatic word_t ki_gain(input axis_t ax);
        case (ax)
            AXIS_YAW: return KI_YAW;
            AXIS_Z:   return KI_Z;
            default:  return KI_XY;
        endcase
    endfunction

    function automatic word_t kd_gain(input axis_t ax);
        case (ax)
            AXIS_YAW: return KD_YAW;
            AXIS_Z:   return KD_Z;
            default:  return KD_XY;
        endcase
    endfunction

    function automatic word_t sat_wide(input logic signed [DATA_WIDTH:0] v);
        if (v[DATA_WIDTH] != v[DATA_WIDTH-1]) begin
            return v[DATA_WIDTH] ? WORD_MIN : WORD_MAX;
        end
        return v[DATA_WIDTH-1:0];
    endfunction

    function automatic word_t sat_add(input word_t a, input word_t b);
        logic signed [DATA_WIDTH:0] s;
        s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
        return sat_wide(s);
    endfunction

    function automatic word_t sat_sub(input word_t a, input word_t b);
        logic signed [DATA_WIDTH:0] s;
        s = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
        return sat_wide(s);
    endfunction

    // floor of product / 2^frac, saturated to a word
    function automatic word_t sat_q(input prod_t p);
        logic [PROD_W-FRAC_BITS-DATA_WIDTH:0] top;
        top = p[PROD_W-1:FRAC_BITS+DATA_WIDTH-1];
        if ((&top) || !(|top)) begin
            return p[FRAC_BITS+DATA_WIDTH-1:FRAC_BITS];
        end
        return p[PROD_W-1] ? WORD_MIN : WORD_MAX;
    endfunction

    function automatic word_t clamp_word(input word_t v, input word_t lo, input word_t hi);
        word_t r;
        r = v;
        if (r < lo) r = lo;
        if (r > hi) r = hi;
        return r;
    endfunction

endpackage

// File: rtl/core/fapat_dp.sv
// fapat_dp: datapath of the four-axis pid unit: configuration registers,
// error capture, one shared 32x32 multiplier, integrators and output clamps
// depends on fapat_pkg

module fapat_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  fapat_pkg::cmd_t                      cmd,
    input  logic                                 cfg_wr_en,
    input  logic [fapat_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fapat_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  fapat_pkg::word_t                     s_target_x,
    input  fapat_pkg::word_t                     s_target_y,
    input  fapat_pkg::word_t                     s_target_z,
    input  fapat_pkg::word_t                     s_target_heading,
    input  fapat_pkg::word_t                     s_measured_x,
    input  fapat_pkg::word_t                     s_measured_y,
    input  fapat_pkg::word_t                     s_measured_z,
    input  fapat_pkg::word_t                     s_measured_heading,
    input  logic                                 s_hover,
    output logic signed [fapat_pkg::OUT_W-1:0]   m_roll_command,
    output logic signed [fapat_pkg::OUT_W-1:0]   m_pitch_command,
    output logic signed [fapat_pkg::OUT_W-1:0]   m_yaw_command,
    output logic signed [fapat_pkg::OUT_W-1:0]   m_throttle_command
);

    logic [fapat_pkg::TS_W-1:0]          time_step_reg;
    logic [fapat_pkg::RATE_W-1:0]        step_rate_reg;
    logic [fapat_pkg::THR_W-1:0]         int_thr_reg;
    logic [fapat_pkg::THR_W-1:0]         yaw_gate_reg;
    logic signed [fapat_pkg::LIM_W-1:0]  thr_bias_reg;
    logic [fapat_pkg::TILT_W-1:0]        tilt_reg;
    logic signed [fapat_pkg::LIM_W-1:0]  thr_min_reg;
    logic signed [fapat_pkg::LIM_W-1:0]  thr_max_reg;

    fapat_pkg::word_t err_reg   [fapat_pkg::NUM_AXES];
    fapat_pkg::word_t prev_reg  [fapat_pkg::NUM_AXES];
    fapat_pkg::word_t integ_reg [fapat_pkg::NUM_AXES];
    fapat_pkg::word_t u_reg     [fapat_pkg::NUM_AXES];
    logic             hover_reg;

    fapat_pkg::word_t  d_reg;
    fapat_pkg::word_t  integ_cur_reg;
    fapat_pkg::word_t  acc_reg;
    fapat_pkg::prod_t  prod_reg;
    fapat_pkg::op_t    post_op_reg;
    fapat_pkg::axis_t  post_axis_reg;
    logic              post_vld_reg;
    logic              clr_reg;

    logic signed [fapat_pkg::OUT_W-1:0] roll_reg;
    logic signed [fapat_pkg::OUT_W-1:0] pitch_reg;
    logic signed [fapat_pkg::OUT_W-1:0] yaw_reg;
    logic signed [fapat_pkg::OUT_W-1:0] throttle_reg;

    fapat_pkg::word_t                 err_sel;
    fapat_pkg::word_t                 mul_a;
    fapat_pkg::word_t                 mul_b;
    logic [fapat_pkg::DATA_WIDTH-1:0] err_mag;
    logic                             clr_flag;
    fapat_pkg::word_t                 q;
    fapat_pkg::word_t                 integ_next;

    fapat_pkg::word_t tilt_w;
    fapat_pkg::word_t neg_tilt_w;
    fapat_pkg::word_t roll_clamped;
    fapat_pkg::word_t pitch_clamped;
    fapat_pkg::word_t yaw_clamped;
    fapat_pkg::word_t thr_sum;
    fapat_pkg::word_t thr_clamped;
    logic             yaw_gate;

    // configuration, indexes above the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_step_reg <= 17'd3277;
            step_rate_reg <= 31'd1310720;
            int_thr_reg   <= 31'd13107;
            yaw_gate_reg  <= 31'd655360;
            thr_bias_reg  <= 18'sd26214;
            tilt_reg      <= 17'd19661;
            thr_min_reg   <= -18'sd32768;
            thr_max_reg   <= 18'sd52429;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                fapat_pkg::REG_TIME_STEP:  time_step_reg <= cfg_data[fapat_pkg::TS_W-1:0];
                fapat_pkg::REG_STEP_RATE:  step_rate_reg <= cfg_data[fapat_pkg::RATE_W-1:0];
                fapat_pkg::REG_INT_THR:    int_thr_reg   <= cfg_data[fapat_pkg::THR_W-1:0];
                fapat_pkg::REG_YAW_GATE:   yaw_gate_reg  <= cfg_data[fapat_pkg::THR_W-1:0];
                fapat_pkg::REG_THR_BIAS:   thr_bias_reg  <= cfg_data[fapat_pkg::LIM_W-1:0];
                fapat_pkg::REG_TILT_LIMIT: tilt_reg      <= cfg_data[fapat_pkg::TILT_W-1:0];
                fapat_pkg::REG_THR_MIN:    thr_min_reg   <= cfg_data[fapat_pkg::LIM_W-1:0];
                fapat_pkg::REG_THR_MAX:    thr_max_reg   <= cfg_data[fapat_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // operand select for the shared multiplier
    always_comb begin
        err_sel  = err_reg[cmd.mul_axis];
        err_mag  = err_sel[fapat_pkg::DATA_WIDTH-1] ? $unsigned(-err_sel) : $unsigned(err_sel);
        clr_flag = err_mag > {1'b0, int_thr_reg};
        case (cmd.mul_op)
            fapat_pkg::OP_DIFF: begin
                mul_a = fapat_pkg::sat_sub(err_sel, prev_reg[cmd.mul_axis]);
                mul_b = {1'b0, step_rate_reg};
            end
            fapat_pkg::OP_TS: begin
                mul_a = err_sel;
                mul_b = {{(fapat_pkg::DATA_WIDTH-fapat_pkg::TS_W){1'b0}}, time_step_reg};
            end
            fapat_pkg::OP_KP: begin
                mul_a = err_sel;
                mul_b = fapat_pkg::kp_gain(cmd.mul_axis);
            end
            fapat_pkg::OP_KI: begin
                mul_a = integ_cur_reg;
                mul_b = fapat_pkg::ki_gain(cmd.mul_axis);
            end
            fapat_pkg::OP_KD: begin
                mul_a = d_reg;
                mul_b = fapat_pkg::kd_gain(cmd.mul_axis);
            end
            default: begin
                mul_a = err_sel;
                mul_b = '0;
            end
        endcase
    end

    // post-multiply stage works on the product registered last cycle
    always_comb begin
        q = fapat_pkg::sat_q(prod_reg);
        if (!hover_reg || clr_reg) begin
            integ_next = '0;
        end else begin
            integ_next = fapat_pkg::sat_add(integ_reg[post_axis_reg], q);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            post_vld_reg <= 1'b0;
        end else begin
            post_vld_reg <= cmd.mul_en;
        end
    end

    // loop state, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < fapat_pkg::NUM_AXES; i++) begin
                prev_reg[i]  <= '0;
                integ_reg[i] <= '0;
            end
        end else begin
            if (cmd.mul_en && cmd.mul_op == fapat_pkg::OP_KD) begin
                prev_reg[cmd.mul_axis] <= err_sel;
            end
            if (post_vld_reg && post_op_reg == fapat_pkg::OP_TS) begin
                integ_reg[post_axis_reg] <= integ_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_err) begin
            err_reg[fapat_pkg::AXIS_X]   <= fapat_pkg::sat_sub(s_target_x, s_measured_x);
            // y error is negated
            err_reg[fapat_pkg::AXIS_Y]   <= fapat_pkg::sat_sub(s_measured_y, s_target_y);
            err_reg[fapat_pkg::AXIS_YAW] <= fapat_pkg::sat_sub(s_target_heading,
                                                               s_measured_heading);
            err_reg[fapat_pkg::AXIS_Z]   <= fapat_pkg::sat_sub(s_target_z, s_measured_z);
            hover_reg                    <= s_hover;
        end
        if (cmd.mul_en) begin
            prod_reg      <= mul_a * mul_b;
            post_op_reg   <= cmd.mul_op;
            post_axis_reg <= cmd.mul_axis;
            clr_reg       <= clr_flag;
        end
        if (post_vld_reg) begin
            case (post_op_reg)
                fapat_pkg::OP_DIFF: d_reg         <= q;
                fapat_pkg::OP_TS:   integ_cur_reg <= integ_next;
                fapat_pkg::OP_KP:   acc_reg       <= q;
                fapat_pkg::OP_KI:   acc_reg       <= fapat_pkg::sat_add(acc_reg, q);
                fapat_pkg::OP_KD:   u_reg[post_axis_reg] <= fapat_pkg::sat_add(acc_reg, q);
                default: ;
            endcase
        end
    end

    // output shaping: tilt clamp, throttle bias and limits, yaw gate
    always_comb begin
        tilt_w        = fapat_pkg::word_t'(tilt_reg);
        neg_tilt_w    = -tilt_w;
        roll_clamped  = fapat_pkg::clamp_word(u_reg[fapat_pkg::AXIS_X], neg_tilt_w, tilt_w);
        pitch_clamped = fapat_pkg::clamp_word(u_reg[fapat_pkg::AXIS_Y], neg_tilt_w, tilt_w);
        yaw_clamped   = fapat_pkg::clamp_word(u_reg[fapat_pkg::AXIS_YAW], neg_tilt_w, tilt_w);
        thr_sum       = fapat_pkg::sat_add(fapat_pkg::word_t'(thr_bias_reg),
                                           u_reg[fapat_pkg::AXIS_Z]);
        thr_clamped   = fapat_pkg::clamp_word(thr_sum, fapat_pkg::word_t'(thr_min_reg),
                                              fapat_pkg::word_t'(thr_max_reg));
        yaw_gate      = err_reg[fapat_pkg::AXIS_YAW] > fapat_pkg::word_t'(yaw_gate_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            roll_reg     <= yaw_gate ? '0 : roll_clamped[fapat_pkg::OUT_W-1:0];
            pitch_reg    <= yaw_gate ? '0 : pitch_clamped[fapat_pkg::OUT_W-1:0];
            yaw_reg      <= yaw_clamped[fapat_pkg::OUT_W-1:0];
            throttle_reg <= thr_clamped[fapat_pkg::OUT_W-1:0];
        end
    end

    assign m_roll_command     = roll_reg;
    assign m_pitch_command    = pitch_reg;
    assign m_yaw_command      = yaw_reg;
    assign m_throttle_command = throttle_reg;

endmodule

// File: rtl/core/fapat_ctrl.sv
// fapat_ctrl: sequencer of the four-axis pid unit; walks five multiply ops
// per axis over the four axes and runs the input and output handshakes
// depends on fapat_pkg

module fapat_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    output fapat_pkg::cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_TAIL,
        ST_FIN
    } state_t;

    state_t            state_reg;
    fapat_pkg::op_t    phase_reg;
    fapat_pkg::axis_t  axis_reg;
    logic              m_valid_reg;
    logic              in_fire;

    assign s_ready = (state_reg == ST_IDLE);
    assign in_fire = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd.load_err = in_fire;
        cmd.mul_en   = (state_reg == ST_RUN);
        cmd.mul_op   = phase_reg;
        cmd.mul_axis = axis_reg;
        // result register is free or being drained this cycle
        cmd.load_out = (state_reg == ST_FIN) && (!m_valid_reg || m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= fapat_pkg::OP_DIFF;
            axis_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        state_reg <= ST_RUN;
                        phase_reg <= fapat_pkg::OP_DIFF;
                        axis_reg  <= '0;
                    end
                end
                ST_RUN: begin
                    case (phase_reg)
                        fapat_pkg::OP_DIFF: phase_reg <= fapat_pkg::OP_TS;
                        fapat_pkg::OP_TS:   phase_reg <= fapat_pkg::OP_KP;
                        fapat_pkg::OP_KP:   phase_reg <= fapat_pkg::OP_KI;
                        fapat_pkg::OP_KI:   phase_reg <= fapat_pkg::OP_KD;
                        fapat_pkg::OP_KD: begin
                            phase_reg <= fapat_pkg::OP_DIFF;
                            if (axis_reg == fapat_pkg::AXIS_W'(fapat_pkg::NUM_AXES - 1)) begin
                                state_reg <= ST_TAIL;
                            end else begin
                                axis_reg <= axis_reg + fapat_pkg::AXIS_W'(1);
                            end
                        end
                        default: phase_reg <= fapat_pkg::OP_DIFF;
                    endcase
                end
                // last product drains through the post stage
                ST_TAIL: state_reg <= ST_FIN;
                ST_FIN: begin
                    if (cmd.load_out) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/core/four_axis_pid_attitude_throttle_unit.sv
// four_axis_pid_attitude_throttle_unit: top level of the four-axis pid unit
// joins the sequencer (fapat_ctrl) and the datapath (fapat_dp)
// depends on fapat_pkg, fapat_ctrl, fapat_dp
//
//   channel   handshake            payload
//   cfg       cfg_wr_en            cfg_index, cfg_data
//   s_        s_valid / s_ready    targets, measurements, hover
//   m_        m_valid / m_ready    roll, pitch, yaw, throttle commands
//
// the result of a beat is presented after 20 multiplies through the single
// shared multiplier (five per axis), a tail step that drains the last
// product and a final step that shapes the outputs. a new beat is taken only
// when the sequencer is idle, so not before the last result is loaded, while
// a finished result may still wait in the output register; a stalled result
// holds the sequencer in its last step. reset is synchronous and clears the
// integrators and previous errors at once.

module four_axis_pid_attitude_throttle_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [fapat_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fapat_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [31:0]                   s_target_x,
    input  logic signed [31:0]                   s_target_y,
    input  logic signed [31:0]                   s_target_z,
    input  logic signed [31:0]                   s_target_heading,
    input  logic signed [31:0]                   s_measured_x,
    input  logic signed [31:0]                   s_measured_y,
    input  logic signed [31:0]                   s_measured_z,
    input  logic signed [31:0]                   s_measured_heading,
    input  logic                                 s_hover,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [fapat_pkg::OUT_W-1:0]   m_roll_command,
    output logic signed [fapat_pkg::OUT_W-1:0]   m_pitch_command,
    output logic signed [fapat_pkg::OUT_W-1:0]   m_yaw_command,
    output logic signed [fapat_pkg::OUT_W-1:0]   m_throttle_command
);

    fapat_pkg::cmd_t cmd;

    fapat_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    fapat_dp u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_target_x         (s_target_x),
        .s_target_y         (s_target_y),
        .s_target_z         (s_target_z),
        .s_target_heading   (s_target_heading),
        .s_measured_x       (s_measured_x),
        .s_measured_y       (s_measured_y),
        .s_measured_z       (s_measured_z),
        .s_measured_heading (s_measured_heading),
        .s_hover            (s_hover),
        .m_roll_command     (m_roll_command),
        .m_pitch_command    (m_pitch_command),
        .m_yaw_command      (m_yaw_command),
        .m_throttle_command (m_throttle_command)
    );

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid || m_ready))
        else $error("result register overwritten while pending");

    // no beat is taken while the multiplier sequence runs
    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul_en |-> !s_ready)
        else $error("input accepted during computation");

    // an accepted beat starts the sequence on the next cycle
    a_start_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (cmd.mul_en && !s_ready))
        else $error("sequence did not start after accept");

endmodule
